FILE: sv/subarray_sum_equals_k_counter_top_defines.svh
// Assertion macros for the subarray sum counter.
// Included by the top level; no other dependencies.
`ifndef SUBARRAY_SUM_EQUALS_K_COUNTER_TOP_DEFINES_SVH
`define SUBARRAY_SUM_EQUALS_K_COUNTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SSEK_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSEK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSEK_ASSERT_SAME(label, clk, rst, ante, cons)
`define SSEK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/ssek_pkg.sv
// Shared widths, constants and the item record that moves along the cell chain.
// No dependencies.
package ssek_pkg;

  localparam int DATA_W = 32;
  localparam int COUNT_W = 16;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int OUT_SLOTS = 2;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic [DATA_W-1:0]  sum;
    logic [DATA_W-1:0]  key;
    logic [COUNT_W-1:0] add;
    logic               found;
    logic               placed;
  } item_t;

endpackage

FILE: sv/ssek_head.sv
// Head stage: running prefix sum and lookup key for each accepted element.
// Depends on ssek_pkg.
module ssek_head (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         accept,
  input  logic [ssek_pkg::DATA_W-1:0]  value,
  input  logic                         first,
  input  logic [ssek_pkg::DATA_W-1:0]  target,
  output ssek_pkg::item_t              dout
);
  import ssek_pkg::*;

  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] sum_next;
  item_t             dout_next;

  always_comb begin
    sum_next = (first ? '0 : sum) + value;
    dout_next = '0;
    dout_next.valid = accept;
    dout_next.first = first;
    dout_next.sum = sum_next;
    dout_next.key = sum_next - target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      dout <= '0;
    end else if (en) begin
      dout <= dout_next;
      if (accept) begin
        sum <= sum_next;
      end
    end
  end

endmodule

FILE: sv/ssek_cell.sv
// One table entry: matches passing items against its key and updates its count.
// Depends on ssek_pkg.
module ssek_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ssek_pkg::item_t din,
  output ssek_pkg::item_t dout
);
  import ssek_pkg::*;

  localparam logic               RESET_VALID = (CELL_INDEX == 0);
  localparam logic [COUNT_W-1:0] RESET_COUNT = (CELL_INDEX == 0) ? COUNT_W'(1) : '0;

  logic               ent_valid;
  logic [DATA_W-1:0]  ent_key;
  logic [COUNT_W-1:0] ent_count;
  logic               ent_valid_next;
  logic [DATA_W-1:0]  ent_key_next;
  logic [COUNT_W-1:0] ent_count_next;
  logic               cur_valid;
  logic [DATA_W-1:0]  cur_key;
  logic [COUNT_W-1:0] cur_count;
  logic               lookup_hit;
  logic               sum_hit;
  logic               alloc;
  item_t              dout_next;

  always_comb begin
    cur_valid = din.first ? RESET_VALID : ent_valid;
    cur_key = din.first ? '0 : ent_key;
    cur_count = din.first ? RESET_COUNT : ent_count;
    lookup_hit = cur_valid && (cur_key == din.key);
    sum_hit = cur_valid && (cur_key == din.sum);
    alloc = !cur_valid && !din.found && !din.placed;

    ent_valid_next = cur_valid;
    ent_key_next = cur_key;
    ent_count_next = cur_count;
    if (sum_hit) begin
      if (cur_count != '1) begin
        ent_count_next = cur_count + COUNT_W'(1);
      end
    end else if (alloc) begin
      ent_valid_next = 1'b1;
      ent_key_next = din.sum;
      ent_count_next = COUNT_W'(1);
    end

    dout_next = din;
    if (lookup_hit) begin
      dout_next.add = cur_count;
    end
    dout_next.found = din.found || sum_hit;
    dout_next.placed = din.placed || alloc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= RESET_VALID;
      ent_key <= '0;
      ent_count <= RESET_COUNT;
      dout <= '0;
    end else if (en) begin
      dout <= dout_next;
      if (din.valid) begin
        ent_valid <= ent_valid_next;
        ent_key <= ent_key_next;
        ent_count <= ent_count_next;
      end
    end
  end

endmodule

FILE: sv/ssek_tail.sv
// Tail stage: saturating total, sticky overflow flag and a two-slot output buffer.
// Depends on ssek_pkg.
module ssek_tail (
  input  logic                        clk,
  input  logic                        rst,
  input  ssek_pkg::item_t             din,
  output logic                        en,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ssek_pkg::DATA_W-1:0] total,
  output logic                        overflow
);
  import ssek_pkg::*;

  localparam int PTR_W = (OUT_SLOTS > 1) ? $clog2(OUT_SLOTS) : 1;
  localparam int CNT_W = $clog2(OUT_SLOTS + 1);

  logic [DATA_W-1:0] acc_total;
  logic              acc_flag;
  logic [DATA_W-1:0] acc_total_next;
  logic              acc_flag_next;
  logic [DATA_W:0]   wide_sum;
  logic [DATA_W-1:0] slot_total [OUT_SLOTS];
  logic              slot_flag [OUT_SLOTS];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              push;
  logic              pop;

  assign en = (fill != CNT_W'(OUT_SLOTS));
  assign out_valid = (fill != '0);
  assign push = en && din.valid;
  assign pop = out_valid && !out_stall;
  assign total = slot_total[rd_ptr];
  assign overflow = slot_flag[rd_ptr];

  always_comb begin
    wide_sum = {1'b0, (din.first ? '0 : acc_total)} + (DATA_W + 1)'(din.add);
    acc_total_next = wide_sum[DATA_W] ? '1 : wide_sum[DATA_W-1:0];
    acc_flag_next = (din.first ? 1'b0 : acc_flag) || (!din.found && !din.placed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_total <= '0;
      acc_flag <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        acc_total <= acc_total_next;
        acc_flag <= acc_flag_next;
        wr_ptr <= (wr_ptr == PTR_W'(OUT_SLOTS - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_SLOTS - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_total[wr_ptr] <= acc_total_next;
      slot_flag[wr_ptr] <= acc_flag_next;
    end
  end

endmodule

FILE: sv/subarray_sum_equals_k_counter_top.sv
// Top level of the subarray sum counter: head stage, chain of table cells, tail.
// Depends on ssek_pkg, ssek_head, ssek_cell, ssek_tail and the defines header.
//
// Input channel: value and first with in_valid / in_stall; a transfer happens
// when in_valid is high and in_stall is low. first starts a new array.
// Output channel: total and overflow with out_valid / out_stall, one result
// per input element, in order.
// Configuration: target_sum is written when cfg_valid and cfg_ready are both
// high; cfg_ready is always high. Write it only while the block is idle.
// Each element walks through the head register, one cell per table entry and
// the tail's output buffer before its result appears. One element per cycle
// is sustained while the output buffer has a free slot; the rate is set by
// the running-sum register in the head stage.
// A two-slot output buffer absorbs results while the receiver stalls; when
// both slots are full the whole chain holds and in_stall rises.
// Reset clears the sum, total and overflow flag, sets the target to zero and
// leaves the table holding only the prefix sum zero with count one.
`include "subarray_sum_equals_k_counter_top_defines.svh"
module subarray_sum_equals_k_counter_top #(
  parameter int TABLE_DEPTH = ssek_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ssek_pkg::DATA_W-1:0] value,
  input  logic                        first,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ssek_pkg::DATA_W-1:0] total,
  output logic                        overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ssek_pkg::DATA_W-1:0] target_sum
);
  import ssek_pkg::*;

  logic              en;
  logic              accept;
  logic [DATA_W-1:0] target;
  item_t             chain [TABLE_DEPTH + 1];

  assign in_stall = !en;
  assign accept = in_valid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_valid && cfg_ready) begin
      target <= target_sum;
    end
  end

  ssek_head u_head (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .accept (accept),
    .value  (value),
    .first  (first),
    .target (target),
    .dout   (chain[0])
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ssek_cell #(
      .CELL_INDEX (i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i + 1])
    );
  end

  ssek_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .din       (chain[TABLE_DEPTH]),
    .en        (en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .total     (total),
    .overflow  (overflow)
  );

  `SSEK_ASSERT_SAME(a_found_or_placed, clk, rst, chain[TABLE_DEPTH].valid, !(chain[TABLE_DEPTH].found && chain[TABLE_DEPTH].placed))
  `SSEK_ASSERT_NEXT(a_hold_on_freeze, clk, rst, !en, $stable(chain[0]))
  `SSEK_ASSERT_NEXT(a_first_restarts_sum, clk, rst, accept && first, chain[0].sum == $past(value))

endmodule

FILE: dv/tb_subarray_sum_equals_k_counter_top.sv
// Testbench for subarray_sum_equals_k_counter_top: directed and random element streams,
// checked against a prefix-sum table predictor kept inside this file.
// Depends on ssek_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module tb_subarray_sum_equals_k_counter_top;
  import ssek_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int REPEAT_RUN = 40;

  typedef struct {
    logic [DATA_W-1:0] total;
    logic              overflow;
  } tally_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] value = '0;
  logic              first = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] total;
  logic              overflow;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DATA_W-1:0] target_sum = '0;

  subarray_sum_equals_k_counter_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .value(value), .first(first),
    .out_valid(out_valid), .out_stall(out_stall), .total(total), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .target_sum(target_sum)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [DATA_W-1:0]  mdl_target;
  logic [DATA_W-1:0]  mdl_sum;
  logic [DATA_W-1:0]  mdl_keys [DEPTH];
  logic [COUNT_W-1:0] mdl_counts [DEPTH];
  bit                 mdl_used [DEPTH];
  logic [DATA_W-1:0]  mdl_total;
  bit                 mdl_full;

  tally_t pending_tallies[$];
  int     errors = 0;
  bit     tx_idle = 1'b1;
  bit     rx_idle = 1'b1;
  int     stall_left = 0;
  int     idle_cycles = 0;
  tally_t head_tally;

  task automatic clear_prefix_table();
    for (int i = 0; i < DEPTH; i++) begin
      mdl_keys[i] = '0;
      mdl_counts[i] = '0;
      mdl_used[i] = 1'b0;
    end
    mdl_counts[0] = COUNT_W'(1);
    mdl_used[0] = 1'b1;
    mdl_sum = '0;
    mdl_total = '0;
    mdl_full = 1'b0;
  endtask

  task automatic count_subarrays(input logic [DATA_W-1:0] v, input logic f,
                                 output tally_t r);
    logic [DATA_W-1:0] key;
    logic [DATA_W:0]   acc;
    int                hit;
    int                slot;
    if (f) clear_prefix_table();
    mdl_sum = mdl_sum + v;
    key = mdl_sum - mdl_target;
    hit = -1;
    for (int i = 0; i < DEPTH; i++)
      if (hit < 0 && mdl_used[i] && mdl_keys[i] == key) hit = i;
    if (hit >= 0) begin
      acc = {1'b0, mdl_total} + {{(DATA_W + 1 - COUNT_W){1'b0}}, mdl_counts[hit]};
      mdl_total = acc[DATA_W] ? '1 : acc[DATA_W-1:0];
    end
    hit = -1;
    for (int i = 0; i < DEPTH; i++)
      if (hit < 0 && mdl_used[i] && mdl_keys[i] == mdl_sum) hit = i;
    if (hit >= 0) begin
      if (mdl_counts[hit] != '1) mdl_counts[hit] = mdl_counts[hit] + COUNT_W'(1);
    end else begin
      slot = -1;
      for (int i = 0; i < DEPTH; i++)
        if (slot < 0 && !mdl_used[i]) slot = i;
      if (slot >= 0) begin
        mdl_used[slot] = 1'b1;
        mdl_keys[slot] = mdl_sum;
        mdl_counts[slot] = COUNT_W'(1);
      end else begin
        mdl_full = 1'b1;
      end
    end
    r.total = mdl_total;
    r.overflow = mdl_full;
  endtask

  task automatic send_elem(input logic [DATA_W-1:0] v, input logic f);
    int     gap;
    tally_t r;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    first <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    count_subarrays(v, f, r);
    pending_tallies = {pending_tallies, r};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic write_target(input logic [DATA_W-1:0] t);
    wait_drained();
    cfg_valid <= 1'b1;
    target_sum <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mdl_target = t;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_elem();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return DATA_W'($signed($urandom_range(0, 8)) - 4);
    if (pick < 17) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      default: return '0;
    endcase
  endfunction

  task automatic test_after_reset();
    send_elem(32'd0, 1'b0);
    send_elem(32'd3, 1'b0);
    send_elem(-32'sd3, 1'b0);
    send_elem(32'd0, 1'b0);
    send_elem(32'd7, 1'b1);
    send_elem(-32'sd7, 1'b0);
  endtask

  task automatic test_extremes();
    write_target(32'h7FFF_FFFF);
    send_elem(32'h7FFF_FFFF, 1'b1);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'h0000_0001, 1'b0);
    send_elem(32'h7FFF_FFFF, 1'b0);
    write_target(32'h8000_0000);
    send_elem(32'h8000_0000, 1'b1);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'hFFFF_FFFF, 1'b0);
    send_elem(32'h0000_0001, 1'b0);
    send_elem(32'h8000_0000, 1'b0);
    write_target(32'hFFFF_FFFF);
    send_elem(32'hFFFF_FFFF, 1'b1);
    send_elem(32'h0000_0000, 1'b0);
    send_elem(32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_table_full();
    write_target(32'd0);
    send_elem(32'd1, 1'b1);
    repeat (DEPTH + 4) send_elem(32'd1, 1'b0);
    repeat (3) send_elem(32'd0, 1'b0);
    send_elem(DATA_W'(-(DEPTH + 4)), 1'b0);
    send_elem(32'd5, 1'b1);
  endtask

  task automatic test_repeated_sum();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_target(32'd0);
    send_elem(32'd0, 1'b1);
    repeat (REPEAT_RUN) send_elem(32'd0, 1'b0);
    send_elem(32'd0, 1'b1);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random();
    logic [DATA_W-1:0] tgt;
    int                len;
    int                sent;
    logic              f;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: tgt = '0;
        1: tgt = DATA_W'($signed($urandom_range(0, 6)) - 3);
        2: tgt = 32'h7FFF_FFFF;
        3: tgt = 32'h8000_0000;
        4: tgt = $urandom;
        default: tgt = DATA_W'($signed($urandom_range(0, 4)) - 2);
      endcase
      write_target(tgt);
      sent = 0;
      while (sent < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 30);
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) == 0) wait_drained();
        for (int i = 0; i < len; i++) begin
          if (i == 0) f = ($urandom_range(0, 9) != 0);
          else f = ($urandom_range(0, 49) == 0);
          send_elem(rand_elem(), f);
          sent++;
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      stall_left = rx_idle ? $urandom_range(0, 19) : 0;
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual total %0d overflow %0d",
                 $time, total, overflow);
        errors++;
      end else begin
        head_tally = pending_tallies.pop_front();
        if (total !== head_tally.total) begin
          $display("%0t: total mismatch, expected %0d, actual %0d",
                   $time, head_tally.total, total);
          errors++;
        end
        if (overflow !== head_tally.overflow) begin
          $display("%0t: overflow mismatch, expected %0d, actual %0d",
                   $time, head_tally.overflow, overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mdl_target = '0;
    clear_prefix_table();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_extremes();
    test_table_full();
    test_repeated_sum();
    test_random();
    wait_drained();
    repeat (DEPTH + 20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
